### sv/dslw_pkg.sv
// Shared constants, types and the digit segment table for the decimal segment LCD writer.
// No dependencies; every other source file but tb_top refers to this package by scoped names.
package dslw_pkg;

   localparam int DIGIT_POSITIONS = 6;
   localparam int ROW_STRIDE      = 5;
   localparam int NIBBLE_ROWS     = 4;
   localparam int MEM_DEPTH       = 20;

   localparam int ADDR_W = 5;
   localparam int DATA_W = 8;
   localparam int NUM_W  = 32;
   // Positive numbers fit in 31 bits; a quotient by ten fits in 28.
   localparam int Y_W    = NUM_W - 1;
   localparam int Q_W    = Y_W - 3;

   localparam int POS_W  = (DIGIT_POSITIONS > 1) ? $clog2(DIGIT_POSITIONS) : 1;
   localparam int ROW_W  = (NIBBLE_ROWS > 1) ? $clog2(NIBBLE_ROWS) : 1;
   localparam int RCNT_W = $clog2(NIBBLE_ROWS + 1);

   // Division by ten as a multiply by the rounded reciprocal 2^35 / 10.
   localparam logic [31:0] RECIP       = 32'hCCCC_CCCD;
   localparam int          RECIP_SHIFT = 35;
   localparam int          PROD_W      = Y_W + 32;

   localparam logic [DATA_W-1:0] KEEP_ODD  = 8'h0f;
   localparam logic [DATA_W-1:0] KEEP_EVEN = 8'hf0;

   typedef enum logic [1:0] {
      S_IDLE,
      S_MUL,
      S_DIV,
      S_RMW
   } state_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
   } wr_type;

   function automatic logic [15:0] seg_pattern(input logic [3:0] digit);
      logic [15:0] pat;
      unique case (digit)
         4'd0:    pat = 16'h1551;
         4'd1:    pat = 16'h0118;
         4'd2:    pat = 16'h1e11;
         4'd3:    pat = 16'h1b11;
         4'd4:    pat = 16'h0b50;
         4'd5:    pat = 16'h1b41;
         4'd6:    pat = 16'h1f41;
         4'd7:    pat = 16'h4009;
         4'd8:    pat = 16'h1f51;
         4'd9:    pat = 16'h1b51;
         default: pat = 16'h0000;
      endcase
      return pat;
   endfunction

endpackage

### sv/dslw_div10.sv
// Divide-by-ten unit: one registered multiply by the reciprocal, then a correction-free
// quotient extract and remainder subtract. Depends on dslw_pkg.
module dslw_div10 (
   input  logic                        clock,
   input  logic [dslw_pkg::Y_W-1:0]    y,
   output logic [dslw_pkg::Q_W-1:0]    quot,
   output logic [3:0]                  rem
);

   logic [dslw_pkg::PROD_W-1:0] prod_ff;
   logic [dslw_pkg::PROD_W-1:0] prod_in;
   logic [dslw_pkg::Y_W-1:0]    y_ff;
   logic [dslw_pkg::Y_W-1:0]    q_ext;
   logic [dslw_pkg::Y_W-1:0]    q_times10;
   logic [dslw_pkg::Y_W-1:0]    diff;

   assign prod_in = dslw_pkg::PROD_W'(y) * dslw_pkg::PROD_W'(dslw_pkg::RECIP);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      y_ff    <= y;
   end

   assign quot      = prod_ff[dslw_pkg::RECIP_SHIFT +: dslw_pkg::Q_W];
   assign q_ext     = dslw_pkg::Y_W'(quot);
   assign q_times10 = (q_ext << 3) + (q_ext << 1);
   assign diff      = y_ff - q_times10;
   assign rem       = diff[3:0];

endmodule

### sv/dslw_seg_ram.sv
// Segment data memory: one write port, one registered read port, write-first on a
// same-address collision, and per-entry valid bits so unwritten bytes read as zero.
// Depends on dslw_pkg.
module dslw_seg_ram (
   input  logic                           clock,
   input  logic                           reset,
   input  dslw_pkg::wr_type               wr,
   input  logic                           rd_en,
   input  logic [dslw_pkg::ADDR_W-1:0]    rd_addr,
   output logic [dslw_pkg::DATA_W-1:0]    rd_data
);

   logic [dslw_pkg::DATA_W-1:0]    mem [0:dslw_pkg::MEM_DEPTH-1];
   logic [dslw_pkg::MEM_DEPTH-1:0] valid_ff;
   logic [dslw_pkg::DATA_W-1:0]    rd_data_ff;
   logic                           rd_hit_ff;
   logic                           rd_in_range;
   logic                           collide;

   assign rd_in_range = rd_addr < dslw_pkg::ADDR_W'(dslw_pkg::MEM_DEPTH);
   assign collide     = wr.en && (wr.addr == rd_addr);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_hit_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_hit_ff <= collide || (rd_in_range && valid_ff[rd_addr]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         if (collide) begin
            rd_data_ff <= wr.data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_hit_ff ? rd_data_ff : '0;

endmodule

### sv/decimal_segment_lcd_writer.sv
// Flow: after an input transfer the first write passes S_MUL, S_DIV, the registered memory
// read and the result register to rsp_. A number with D digits shown takes the idle accept
// and one multiply, then per digit one divide by ten and four pipelined read-modify-writes
// on the single segment memory; a zero or negative number is taken in idle and writes
// nothing. Output stalls hold the flow; no new number is taken until the last write loads.
// Reset (synchronous) returns to idle and marks every memory byte as zero.
module decimal_segment_lcd_writer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [31:0]             req_number,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [4:0]                     rsp_reg_index,
   output logic [7:0]                     rsp_reg_value,
   output logic                           rsp_last_write
);

   dslw_pkg::state_type state_ff, state_in;

   logic [dslw_pkg::Y_W-1:0]     y_ff;
   logic [dslw_pkg::POS_W-1:0]   pos_ff;
   logic [15:0]                  pattern_ff;
   logic                         last_digit_ff;
   logic [dslw_pkg::ADDR_W-1:0]  rd_addr_ff;
   logic [dslw_pkg::RCNT_W-1:0]  rd_k_ff;
   logic [dslw_pkg::ADDR_W-1:0]  wr_addr_ff;
   logic [dslw_pkg::ROW_W-1:0]   wr_k_ff;
   logic                         pend_ff;

   logic                         rsp_valid_ff;
   logic [dslw_pkg::ADDR_W-1:0]  rsp_reg_index_ff;
   logic [dslw_pkg::DATA_W-1:0]  rsp_reg_value_ff;
   logic                         rsp_last_write_ff;

   logic [dslw_pkg::Q_W-1:0]     div_quot;
   logic [3:0]                   div_rem;
   logic                         req_fire;
   logic                         num_ok;
   logic                         out_free;
   logic                         advance;
   logic                         rd_more;
   logic                         row_last;
   logic                         issue;
   logic                         out_load;
   logic                         digit_done;
   logic                         load_last;
   logic                         ram_rd_en;
   dslw_pkg::wr_type             ram_wr;
   logic [dslw_pkg::DATA_W-1:0]  ram_rd_data;
   logic [3:0]                   nib;
   logic [dslw_pkg::DATA_W-1:0]  nib_placed;
   logic [dslw_pkg::DATA_W-1:0]  keep_mask;
   logic [dslw_pkg::DATA_W-1:0]  merged;

   dslw_div10 u_div10 (
      .clock (clock),
      .y     (y_ff),
      .quot  (div_quot),
      .rem   (div_rem)
   );

   dslw_seg_ram u_seg_ram (
      .clock   (clock),
      .reset   (reset),
      .wr      (ram_wr),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_addr_ff),
      .rd_data (ram_rd_data)
   );

   assign req_fire = req_valid && !req_stall;
   assign num_ok   = !req_number[31] && (req_number != '0);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign advance  = !pend_ff || out_free;
   assign rd_more  = rd_k_ff < dslw_pkg::RCNT_W'(dslw_pkg::NIBBLE_ROWS);
   assign row_last = wr_k_ff == dslw_pkg::ROW_W'(dslw_pkg::NIBBLE_ROWS - 1);

   // Nibble merge: an odd position owns the high nibble of the byte.
   assign nib        = pattern_ff[{wr_k_ff, 2'b00} +: 4];
   assign keep_mask  = pos_ff[0] ? dslw_pkg::KEEP_ODD : dslw_pkg::KEEP_EVEN;
   assign nib_placed = pos_ff[0] ? {nib, 4'b0000} : {4'b0000, nib};
   assign merged     = (ram_rd_data & keep_mask) | nib_placed;
   assign load_last  = last_digit_ff && row_last;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dslw_pkg::S_IDLE: begin
            if (req_fire && num_ok) begin
               state_in = dslw_pkg::S_MUL;
            end
         end
         dslw_pkg::S_MUL: begin
            state_in = dslw_pkg::S_DIV;
         end
         dslw_pkg::S_DIV: begin
            state_in = dslw_pkg::S_RMW;
         end
         dslw_pkg::S_RMW: begin
            if (digit_done) begin
               state_in = last_digit_ff ? dslw_pkg::S_IDLE : dslw_pkg::S_DIV;
            end
         end
         default: begin
            state_in = dslw_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall  = 1'b1;
      issue      = 1'b0;
      out_load   = 1'b0;
      digit_done = 1'b0;
      unique case (state_ff)
         dslw_pkg::S_IDLE: begin
            req_stall = 1'b0;
         end
         dslw_pkg::S_MUL, dslw_pkg::S_DIV: begin
            req_stall = 1'b1;
         end
         dslw_pkg::S_RMW: begin
            issue      = advance && rd_more;
            out_load   = advance && pend_ff;
            digit_done = advance && pend_ff && row_last;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   assign ram_rd_en   = issue;
   assign ram_wr.en   = out_load && (wr_addr_ff < dslw_pkg::ADDR_W'(dslw_pkg::MEM_DEPTH));
   assign ram_wr.addr = wr_addr_ff;
   assign ram_wr.data = merged;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dslw_pkg::S_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == dslw_pkg::S_DIV) begin
            pend_ff <= 1'b0;
         end else if (state_ff == dslw_pkg::S_RMW && advance) begin
            pend_ff <= rd_more;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == dslw_pkg::S_IDLE && req_fire) begin
         y_ff   <= req_number[dslw_pkg::Y_W-1:0];
         pos_ff <= dslw_pkg::POS_W'(dslw_pkg::DIGIT_POSITIONS - 1);
      end
      if (state_ff == dslw_pkg::S_DIV) begin
         y_ff          <= dslw_pkg::Y_W'(div_quot);
         pattern_ff    <= dslw_pkg::seg_pattern(div_rem);
         last_digit_ff <= (div_quot == '0) || (pos_ff == '0);
         rd_addr_ff    <= dslw_pkg::ADDR_W'(pos_ff >> 1);
         rd_k_ff       <= '0;
      end
      if (issue) begin
         rd_addr_ff <= rd_addr_ff + dslw_pkg::ADDR_W'(dslw_pkg::ROW_STRIDE);
         rd_k_ff    <= rd_k_ff + 1'b1;
         wr_addr_ff <= rd_addr_ff;
         wr_k_ff    <= dslw_pkg::ROW_W'(rd_k_ff);
      end
      if (digit_done) begin
         pos_ff <= pos_ff - 1'b1;
      end
      if (out_load) begin
         rsp_reg_index_ff  <= wr_addr_ff;
         rsp_reg_value_ff  <= merged;
         rsp_last_write_ff <= load_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_reg_index  = rsp_reg_index_ff;
   assign rsp_reg_value  = rsp_reg_value_ff;
   assign rsp_last_write = rsp_last_write_ff;

`ifndef SYNTHESIS
   a_write_has_result: assert property (@(posedge clock) disable iff (reset)
      ram_wr.en |-> out_load)
      else $error("memory write without a result transfer");

   a_pending_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dslw_pkg::S_RMW && pend_ff && !advance)
         |=> (pend_ff && $stable(wr_addr_ff) && $stable(wr_k_ff)))
      else $error("pending merge lost while output was stalled");

   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      (out_load && load_last) |=> (state_ff == dslw_pkg::S_IDLE))
      else $error("last write did not end the item");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dslw_pkg::S_DIV) |-> (div_rem < 4'd10))
      else $error("divide by ten produced a remainder above nine");
`endif

endmodule

### bench/lcd_write_checker.sv
// Checker for the decimal segment LCD writer: predicts the byte writes of every number
// taken in, and compares each result transfer with the oldest predicted write.
// Depends on dslw_pkg for the sizes of the display and its data memory, the row stride and the keep masks.
`timescale 1ns / 1ps

module lcd_write_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [31:0] req_number,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [4:0]         rsp_reg_index,
   input  logic [7:0]         rsp_reg_value,
   input  logic               rsp_last_write,
   output int                 fail_count,
   output int                 pending_writes
);

   typedef struct packed {
      logic [4:0] byte_index;
      logic [7:0] byte_value;
      logic       last_write;
   } lcd_write_type;

   // Segment patterns for the digits 0 to 9, one nibble per LCD row.
   localparam logic [15:0] DIGIT_SEGMENTS [10] = '{
      16'h1551, 16'h0118, 16'h1e11, 16'h1b11, 16'h0b50,
      16'h1b41, 16'h1f41, 16'h4009, 16'h1f51, 16'h1b51
   };

   logic [7:0] lcd_bytes [dslw_pkg::MEM_DEPTH];
   lcd_write_type expected_writes [$];

   initial fail_count = 0;
   initial pending_writes = 0;

   task automatic report_mismatch(input string what);
      fail_count++;
      $display("%0t ns: MISMATCH: %s", $realtime, what);
   endtask

   task automatic predict_writes(input logic [31:0] number);
      logic [30:0]   rest;
      int            pos;
      int            idx;
      logic [15:0]   pattern;
      logic [3:0]    nib;
      logic [7:0]    old_byte;
      logic [7:0]    keep;
      logic [7:0]    merged;
      logic          final_digit;
      lcd_write_type wr;
      if (number == 32'd0 || number[31]) begin
         return;
      end
      rest = number[30:0];
      pos = dslw_pkg::DIGIT_POSITIONS;
      while (rest != 0 && pos > 0) begin
         pos--;
         pattern = DIGIT_SEGMENTS[rest % 10];
         keep = pos[0] ? dslw_pkg::KEEP_ODD : dslw_pkg::KEEP_EVEN;
         final_digit = (rest / 10 == 0) || (pos == 0);
         for (int k = 0; k < dslw_pkg::NIBBLE_ROWS; k++) begin
            idx = pos / 2 + dslw_pkg::ROW_STRIDE * k;
            old_byte = (idx < dslw_pkg::MEM_DEPTH) ? lcd_bytes[idx] : 8'h00;
            nib = pattern[4*k +: 4];
            merged = (old_byte & keep) | (pos[0] ? {nib, 4'h0} : {4'h0, nib});
            if (idx < dslw_pkg::MEM_DEPTH) begin
               lcd_bytes[idx] = merged;
            end
            wr.byte_index = idx[4:0];
            wr.byte_value = merged;
            wr.last_write = final_digit && (k == dslw_pkg::NIBBLE_ROWS - 1);
            expected_writes.push_back(wr);
         end
         rest = rest / 10;
      end
   endtask

   always @(posedge clock) begin
      lcd_write_type wr;
      if (reset) begin
         expected_writes.delete();
         for (int i = 0; i < dslw_pkg::MEM_DEPTH; i++) begin
            lcd_bytes[i] = 8'h00;
         end
      end else begin
         if (req_valid && !req_stall) begin
            predict_writes(req_number);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_writes.size() == 0) begin
               report_mismatch($sformatf("unexpected write index %0d value %02h last %0b",
                  rsp_reg_index, rsp_reg_value, rsp_last_write));
            end else begin
               wr = expected_writes.pop_front();
               if (rsp_reg_index !== wr.byte_index) begin
                  report_mismatch($sformatf("reg_index got %0d expected %0d",
                     rsp_reg_index, wr.byte_index));
               end
               if (rsp_reg_value !== wr.byte_value) begin
                  report_mismatch($sformatf("reg_value got %02h expected %02h (index %0d)",
                     rsp_reg_value, wr.byte_value, wr.byte_index));
               end
               if (rsp_last_write !== wr.last_write) begin
                  report_mismatch($sformatf("last_write got %0b expected %0b (index %0d)",
                     rsp_last_write, wr.last_write, wr.byte_index));
               end
            end
         end
      end
      pending_writes <= expected_writes.size();
   end

endmodule

### bench/tb_top.sv
// Top of the decimal segment LCD writer bench: clock, reset, number stimulus and verdict.
// Depends on the writer RTL, dslw_pkg and the lcd_write_checker module.
`timescale 1ns / 1ps

module tb_top;

   localparam int STALL_LIMIT = 2000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_number = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [4:0]         rsp_reg_index;
   logic [7:0]         rsp_reg_value;
   logic               rsp_last_write;

   int fail_count;
   int pending_writes;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int quiet_cycles = 0;

   decimal_segment_lcd_writer DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_number     (req_number),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_reg_index  (rsp_reg_index),
      .rsp_reg_value  (rsp_reg_value),
      .rsp_last_write (rsp_last_write)
   );

   lcd_write_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_number     (req_number),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_reg_index  (rsp_reg_index),
      .rsp_reg_value  (rsp_reg_value),
      .rsp_last_write (rsp_last_write),
      .fail_count     (fail_count),
      .pending_writes (pending_writes)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Receiver backpressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // The run is cut off when no transfer happens on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offers one number and returns at the edge where it is taken.
   task automatic send_number(input logic signed [31:0] number);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_number <= number;
      do @(posedge clock); while (req_stall);
   endtask

   // Holds the sender off until every predicted write has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_writes != 0) @(posedge clock);
   endtask

   task automatic run_phase(input int send_pct, input int recv_pct, input int shown_target);
      int                 shown;
      int                 pick;
      int                 digits;
      longint             lo;
      longint             hi;
      logic signed [31:0] number;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      shown = 0;
      while (shown < shown_target) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            // Mostly numbers with a chosen digit count, so short numbers leave old digits.
            digits = $urandom_range(1, 10);
            lo = 1;
            repeat (digits - 1) lo *= 10;
            hi = lo * 10 - 1;
            if (hi > 64'sd2147483647) begin
               hi = 64'sd2147483647;
            end
            number = $urandom_range(int'(hi), int'(lo));
         end else if (pick < 75) begin
            number = $urandom & 32'h7fff_ffff;
         end else if (pick < 90) begin
            number = $urandom;
         end else if (pick < 95) begin
            number = -$signed($urandom_range(1000, 1));
         end else begin
            number = 32'sd0;
         end
         send_number(number);
         if (number > 0) begin
            shown++;
         end
      end
      wait_drained();
   endtask

   initial begin
      logic signed [31:0] directed [] = '{
         32'sd1, 32'sd9, 32'sd10, 32'sd99, 32'sd100, 32'sd123456, 32'sd999999,
         32'sd1000000, 32'sd1234567, 32'sd2147483647, 32'sd0, -32'sd1,
         32'h8000_0000, 32'h4000_0000, 32'sd100000, 32'sd5, 32'sd42, 32'sd7,
         32'sd86420, 32'sd13579, 32'sd2, 32'sd3, 32'sd4, 32'sd6, 32'sd8
      };
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 37;
      recv_idle_pct = 55;
      foreach (directed[i]) begin
         send_number(directed[i]);
      end
      wait_drained();

      run_phase(37, 55, 105);
      run_phase(55, 37, 105);
      run_phase(0, 0, 105);

      // Give the block time to show any stray writes after the last expected one.
      repeat (60) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

### decimal_segment_lcd_writer.f
sv/dslw_pkg.sv
sv/dslw_div10.sv
sv/dslw_seg_ram.sv
sv/decimal_segment_lcd_writer.sv
bench/lcd_write_checker.sv
bench/tb_top.sv
